// ----- rtl/core/swo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swo_pkg
// Types, constants and the arctangent table of the swerve wheel odometry.
// ----------------------------------------------------------------------------
package swo_pkg;

	localparam int WHEEL_COUNT    = 4;
	localparam int TRIG_TABLE_LEN = 24;
	localparam int CORDIC_W       = 34;
	localparam int SUM_W          = 56;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [1:0] {
		ACT_KEEP  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_LOAD  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CORDIC,
		ST_MULT,
		ST_DONE
	} state_t;

	localparam int CFG_START_X = 0;
	localparam int CFG_START_Y = 1;

	// Arctangent of 2^-i in units of 2^32 per turn.
	function automatic logic signed [CORDIC_W-1:0] atan_turns(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return $signed({2'b00, v});
	endfunction

endpackage

// ----- rtl/core/swerve_wheel_odometry.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerve_wheel_odometry
// Swerve drive position tracking from gyro heading and four wheel motions.
// ----------------------------------------------------------------------------
// One CORDIC unit, one step a cycle, is shared by the four wheels, and each
// wheel's sine and cosine are then multiplied by its travel bit-serially, one
// travel bit a cycle. The next item is taken once the previous one has moved
// to the output register.
module swerve_wheel_odometry #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic signed [31:0] cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] gyro_angle,
	input  logic signed [15:0] front_left_angle,
	input  logic signed [15:0] front_right_angle,
	input  logic signed [15:0] rear_left_angle,
	input  logic signed [15:0] rear_right_angle,
	input  logic signed [15:0] front_left_travel,
	input  logic signed [15:0] front_right_travel,
	input  logic signed [15:0] rear_left_travel,
	input  logic signed [15:0] rear_right_travel,
	input  logic        [1:0]  position_action,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] position_x,
	output logic signed [31:0] position_y
);
	import swo_pkg::*;

	localparam int STEPS = (TRIG_ITERATIONS > TRIG_TABLE_LEN) ? TRIG_TABLE_LEN
		: TRIG_ITERATIONS;

	state_t state_q, state_d;
	logic [4:0] iter_q;
	logic [3:0] bit_q;
	logic [1:0] wheel_q;
	logic signed [31:0] start_x_q, start_y_q, pos_x_q, pos_y_q, base_x_q, base_y_q;
	logic signed [15:0] gyro_q;
	logic signed [15:0] ang_q [WHEEL_COUNT];
	logic signed [15:0] trav_q [WHEEL_COUNT];
	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic signed [SUM_W-1:0] mx_q, my_q, sum_x_q, sum_y_q;
	logic [15:0] tr_q;
	logic flip_q, out_valid_q;

	logic in_acc, last_iter, last_bit, out_free;
	logic [15:0] rel, rel_f;
	logic flip;
	logic signed [CORDIC_W-1:0] dx, dy, at;
	logic signed [SUM_W-1:0] ts, tc;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign position_x = pos_x_q;
	assign position_y = pos_y_q;
	assign last_iter = (iter_q == 5'(STEPS - 1));
	assign last_bit  = (bit_q == 4'd15);

	// Relative angle, folded into the right half plane.
	assign rel   = gyro_q - ang_q[wheel_q];
	assign flip  = rel[15] ^ rel[14];
	assign rel_f = flip ? (rel ^ 16'h8000) : rel;

	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;
	assign at = atan_turns(iter_q);

	// The travel's top bit has negative weight; the fold flips both signs and
	// the Y sum takes minus cosine.
	always_comb begin
		ts = mx_q;
		tc = my_q;
		if (last_bit ^ flip_q)
			ts = -mx_q;
		if (!(last_bit ^ flip_q))
			tc = -my_q;
	end

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] b,
		input logic signed [SUM_W-1:0] s);
		logic signed [33:0] r;
		r = {{2{b[31]}}, b} + {{10{s[SUM_W-1]}}, s[SUM_W-1:32]};
		if (r > 34'sh07FFFFFFF)
			return 32'sh7FFFFFFF;
		else if (r < -34'sh080000000)
			return -32'sh80000000;
		return r[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_acc) state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_CORDIC;
			ST_CORDIC: if (last_iter) state_d = ST_MULT;
			ST_MULT: begin
				if (last_bit)
					state_d = (wheel_q == 2'(WHEEL_COUNT - 1)) ? ST_DONE : ST_LOAD;
			end
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q   <= '0;
			start_y_q   <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			out_valid_q <= 1'b0;
			iter_q      <= '0;
			bit_q       <= '0;
			wheel_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == 1'(CFG_START_X))
					start_x_q <= cfg_data;
				else
					start_y_q <= cfg_data;
			end
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					wheel_q <= '0;
					if (in_acc) begin
						sum_x_q <= '0;
						sum_y_q <= '0;
						gyro_q  <= gyro_angle;
						ang_q[0] <= front_left_angle;
						ang_q[1] <= front_right_angle;
						ang_q[2] <= rear_left_angle;
						ang_q[3] <= rear_right_angle;
						trav_q[0] <= front_left_travel;
						trav_q[1] <= front_right_travel;
						trav_q[2] <= rear_left_travel;
						trav_q[3] <= rear_right_travel;
						case (action_t'(position_action))
							ACT_CLEAR: begin
								base_x_q <= '0;
								base_y_q <= '0;
							end
							ACT_LOAD: begin
								base_x_q <= start_x_q;
								base_y_q <= start_y_q;
							end
							default: begin
								base_x_q <= pos_x_q;
								base_y_q <= pos_y_q;
							end
						endcase
					end
				end
				ST_LOAD: begin
					x_q    <= CORDIC_GAIN;
					y_q    <= '0;
					z_q    <= {{2{rel_f[15]}}, rel_f, 16'h0000};
					flip_q <= flip;
					iter_q <= '0;
				end
				ST_CORDIC: begin
					if (!z_q[CORDIC_W-1]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + at;
					end
					iter_q <= iter_q + 5'd1;
					bit_q  <= '0;
					tr_q   <= trav_q[wheel_q];
					if (last_iter) begin
						// Results of the final step go straight to the multiplicands.
						if (!z_q[CORDIC_W-1]) begin
							mx_q <= SUM_W'(y_q + dy);
							my_q <= SUM_W'(x_q - dx);
						end else begin
							mx_q <= SUM_W'(y_q - dy);
							my_q <= SUM_W'(x_q + dx);
						end
					end
				end
				ST_MULT: begin
					if (tr_q[0]) begin
						sum_x_q <= sum_x_q + ts;
						sum_y_q <= sum_y_q + tc;
					end
					mx_q  <= mx_q <<< 1;
					my_q  <= my_q <<< 1;
					tr_q  <= tr_q >> 1;
					bit_q <= bit_q + 4'd1;
					if (last_bit)
						wheel_q <= wheel_q + 2'd1;
				end
				ST_DONE: begin
					if (out_free) begin
						pos_x_q     <= sat_add(base_x_q, sum_x_q);
						pos_y_q     <= sat_add(base_y_q, sum_y_q);
					end
				end
				default: ;
			endcase
		end
	end

	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_LOAD)
		else $error("accepted item did not start a wheel");
	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CORDIC |-> iter_q < 5'(STEPS))
		else $error("CORDIC step count overran");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result shown without finishing an item");
	a_wheel_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> wheel_q == 2'd0)
		else $error("wheel count not complete at finish");

endmodule

// ----- dv/swerve_wheel_odometry_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerve_wheel_odometry_test
// Drives heading, wheel angle and wheel travel items into the odometry block
// with random idling on both sides, predicts each position with a CORDIC
// model of its own, and checks every result in order.
// ----------------------------------------------------------------------------
module swerve_wheel_odometry_test;
	import swo_pkg::*;

	localparam int TRIG_STEPS = 16;
	localparam int RANDOM_ITEMS = 1300;
	localparam int ITEM_CYCLES = 4 * (TRIG_STEPS + 17) + 1;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic signed [15:0] gyro;
		logic signed [15:0] fl_ang, fr_ang, rl_ang, rr_ang;
		logic signed [15:0] fl_trv, fr_trv, rl_trv, rr_trv;
		action_t act;
	} motion_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} pose_t;

	typedef struct {
		motion_t m;
		logic known;
		pose_t p;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_index = 0;
	logic signed [31:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_stall;
	motion_t drv = '0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] position_x, position_y;

	logic signed [31:0] start_x_reg = 0, start_y_reg = 0;
	logic signed [31:0] track_x = 0, track_y = 0;
	pose_t pending_poses[$];
	int error_count = 0;
	longint cycle_count = 0;
	bit quiet_phase = 0;
	bit done = 0;

	swerve_wheel_odometry #(.TRIG_ITERATIONS(TRIG_STEPS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.gyro_angle(drv.gyro),
		.front_left_angle(drv.fl_ang), .front_right_angle(drv.fr_ang),
		.rear_left_angle(drv.rl_ang), .rear_right_angle(drv.rr_ang),
		.front_left_travel(drv.fl_trv), .front_right_travel(drv.fr_trv),
		.rear_left_travel(drv.rl_trv), .rear_right_travel(drv.rr_trv),
		.position_action(drv.act),
		.out_valid(out_valid), .out_stall(out_stall),
		.position_x(position_x), .position_y(position_y)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [63:0] atan_step(int i);
		logic [31:0] t[24] = '{
			32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
			32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
		return $signed({32'h0, t[i]});
	endfunction

	// Q2.30 sine and cosine of a binary angle; the back half turn is folded.
	task automatic wheel_sincos(input logic [15:0] rel, output logic signed [63:0] s,
			output logic signed [63:0] c);
		logic signed [63:0] x, y, z, dx, dy;
		logic flip;
		int steps;
		flip = (rel >= 16'h4000 && rel < 16'hC000);
		if (flip)
			rel = rel - 16'h8000;
		x = 64'sd652032874;
		y = 0;
		z = $signed(rel) * 64'sd65536;
		steps = TRIG_STEPS > 24 ? 24 : TRIG_STEPS;
		for (int i = 0; i < steps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i);
			end else begin
				x += dx; y -= dy; z += atan_step(i);
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	task automatic advance_pose(input motion_t m, output pose_t p);
		logic signed [15:0] ang[4], trv[4];
		logic signed [63:0] sx, sy, s, c;
		logic [15:0] rel;
		ang = '{m.fl_ang, m.fr_ang, m.rl_ang, m.rr_ang};
		trv = '{m.fl_trv, m.fr_trv, m.rl_trv, m.rr_trv};
		sx = 0;
		sy = 0;
		if (m.act == ACT_CLEAR) begin
			track_x = 0; track_y = 0;
		end else if (m.act == ACT_LOAD) begin
			track_x = start_x_reg; track_y = start_y_reg;
		end
		for (int w = 0; w < WHEEL_COUNT; w++) begin
			rel = m.gyro - ang[w];
			wheel_sincos(rel, s, c);
			sx += s * trv[w];
			sy -= c * trv[w];
		end
		track_x = clamp32(64'(track_x) + (sx >>> 32));
		track_y = clamp32(64'(track_y) + (sy >>> 32));
		p.x = track_x;
		p.y = track_y;
	endtask

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		error_count++;
	endtask

	function automatic bit idle_now();
		return !quiet_phase && ($urandom_range(99) < 36);
	endfunction

	task automatic write_start(input logic idx, input logic signed [31:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		if (idx == CFG_START_X)
			start_x_reg = v;
		else
			start_y_reg = v;
	endtask

	task automatic settle();
		while (pending_poses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_motion(input motion_t m, input logic known, input pose_t want);
		pose_t p;
		while (idle_now()) begin
			in_valid <= 0;
			@(posedge clk);
		end
		drv <= m;
		in_valid <= 1;
		advance_pose(m, p);
		if (known && p != want) begin
			report_mismatch("directed x", p.x, want.x);
			report_mismatch("directed y", p.y, want.y);
		end
		pending_poses.push_back(p);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	function automatic motion_t random_motion();
		motion_t m;
		logic [159:0] raw;
		int r;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		m = motion_t'(raw[$bits(motion_t)-1:0]);
		r = $urandom_range(99);
		m.act = r < 80 ? ACT_KEEP : r < 88 ? ACT_CLEAR : r < 96 ? ACT_LOAD : ACT_NONE;
		// Mostly realistic small travels, sometimes full range.
		if ($urandom_range(3) != 0) begin
			m.fl_trv = 16'($urandom_range(1023)) - 16'd512;
			m.fr_trv = 16'($urandom_range(1023)) - 16'd512;
			m.rl_trv = 16'($urandom_range(1023)) - 16'd512;
			m.rr_trv = 16'($urandom_range(1023)) - 16'd512;
		end
		return m;
	endfunction

	initial begin
		row_t rows[$];
		motion_t m;
		pose_t z;
		logic signed [31:0] sx[4] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 32'sd123456};
		logic signed [31:0] sy[4] = '{32'sh80000000, 32'sh7FFFFFFF, -32'sd98765, 32'sd0};
		z = '0;
		rows.push_back('{motion_t'('0), 1, z});
		rows.push_back('{'{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh4000, 16'shC000,
			16'sd0, 16'sd0, 16'sd0, 16'sd0, ACT_CLEAR}, 1, z});
		rows.push_back('{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, ACT_KEEP}, 0, z});
		rows.push_back('{'{16'sh8000, 16'sh7FFF, 16'sh4000, 16'shC000, 16'sh3FFF,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, ACT_NONE}, 0, z});
		rows.push_back('{'{16'sh4000, 16'sh0000, 16'shBFFF, 16'sh8000, 16'sh7FFF,
			16'sh7FFF, 16'sh8000, 16'sh0100, 16'shFF00, ACT_KEEP}, 0, z});
		rows.push_back('{'{16'shC000, 16'sh4000, 16'sh0001, 16'shFFFF, 16'sh8001,
			16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh0001, ACT_LOAD}, 0, z});
		rows.push_back('{'{16'sh1234, 16'shFEDC, 16'sh0F0F, 16'shF0F0, 16'sh7FFF,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, ACT_KEEP}, 0, z});
		rows.push_back('{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
			16'sd0, 16'sd0, 16'sd0, 16'sd0, ACT_CLEAR}, 1, z});

		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Extreme and ordinary values of the start registers, each followed by the directed table.
		for (int k = 0; k < 4; k++) begin
			write_start(1'(CFG_START_X), sx[k]);
			write_start(1'(CFG_START_Y), sy[k]);
			// The first row keeps the position, which is zero only after reset.
			foreach (rows[i])
				send_motion(rows[i].m, rows[i].known && (k == 0 || i != 0), rows[i].p);
			// Drive toward saturation from the loaded start values.
			m = '{16'sh0000, 16'shC000, 16'shC000, 16'shC000, 16'shC000,
				16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, ACT_LOAD};
			send_motion(m, 0, z);
			m.act = ACT_KEEP;
			send_motion(m, 0, z);
			in_valid <= 0;
			settle();
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 300 == 299) begin
				in_valid <= 0;
				settle();
				write_start(1'(CFG_START_X), $urandom);
				write_start(1'(CFG_START_Y), $urandom);
			end
			quiet_phase = (n >= 600 && n < 800);
			send_motion(random_motion(), 0, z);
		end
		in_valid <= 0;
		quiet_phase = 0;
		while (pending_poses.size() != 0)
			@(posedge clk);
		repeat (2 * ITEM_CYCLES) @(posedge clk);
		done = 1;
	end

	always @(posedge clk) begin
		if (arst_n)
			out_stall <= idle_now();
	end

	always @(posedge clk) begin
		pose_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_poses.size() == 0) begin
				report_mismatch("unexpected x", position_x, 0);
			end else begin
				want = pending_poses.pop_front();
				if (position_x !== want.x)
					report_mismatch("position_x", position_x, want.x);
				if (position_y !== want.y)
					report_mismatch("position_y", position_y, want.y);
			end
		end
	end

	initial begin
		while (!done && cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		if (!done) begin
			$display("timeout at cycle %0d", cycle_count);
			$display("FAILED: results differ");
		end else if (error_count == 0 && pending_poses.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
